>>> sv/tlp_pkg.sv
// Shared constants and types for the two-level local branch predictor.
`timescale 1ns / 1ps

package tlp_pkg;

   localparam int HISTORY_ENTRIES = 4096;
   localparam int HISTORY_BITS    = 16;
   localparam int COUNTER_ENTRIES = 1 << HISTORY_BITS;
   localparam int HIST_IDX_W      = $clog2(HISTORY_ENTRIES);
   localparam int CLEAR_W         = (HIST_IDX_W > HISTORY_BITS) ? HIST_IDX_W : HISTORY_BITS;
   localparam int COUNT_W         = 32;

   localparam logic [1:0] CTR_MIN = 2'd0;
   localparam logic [1:0] CTR_MAX = 2'd3;

   typedef logic [HIST_IDX_W-1:0]   hist_idx_type;
   typedef logic [HISTORY_BITS-1:0] history_type;
   typedef logic [1:0]              counter_type;
   typedef logic [COUNT_W-1:0]      count_type;

   // Read addresses and write ports of both tables.
   typedef struct packed {
      hist_idx_type hist_rd_addr;
      logic         hist_we;
      hist_idx_type hist_wa;
      history_type  hist_wd;
      history_type  ctr_rd_addr;
      logic         ctr_we;
      history_type  ctr_wa;
      counter_type  ctr_wd;
   } tbl_req_type;

endpackage

>>> sv/tlp_tables.sv
// History table and pattern counter table, synchronous memories with registered reads.
`timescale 1ns / 1ps

module tlp_tables
   import tlp_pkg::*;
(
   input  logic        clock,
   input  tbl_req_type tbl_req,
   output history_type hist_rd_data,
   output counter_type ctr_rd_data
);

   history_type hist_mem [HISTORY_ENTRIES];
   counter_type ctr_mem  [COUNTER_ENTRIES];

   history_type hist_rd_ff;
   counter_type ctr_rd_ff;

   always_ff @(posedge clock) begin
      if (tbl_req.hist_we) begin
         hist_mem[tbl_req.hist_wa] <= tbl_req.hist_wd;
      end
      hist_rd_ff <= hist_mem[tbl_req.hist_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (tbl_req.ctr_we) begin
         ctr_mem[tbl_req.ctr_wa] <= tbl_req.ctr_wd;
      end
      ctr_rd_ff <= ctr_mem[tbl_req.ctr_rd_addr];
   end

   assign hist_rd_data = hist_rd_ff;
   assign ctr_rd_data  = ctr_rd_ff;

endmodule

>>> sv/two_level_local_branch_predictor.sv
// Top level of the two-level local-history branch predictor.
//
//   channel  | ports                                   | transfer when
//   ---------+-----------------------------------------+------------------------
//   request  | start, busy, req_branch_address, req_taken | start & !busy
//   response | rsp_valid, rsp_* fields                 | rsp_valid (one cycle)
//   config   | csr_valid, csr_ready, csr_branch_limit  | csr_valid & csr_ready
//
// Each branch runs from accept to response in order: a read of the history
// table, a read of the counter table addressed by that history, then the
// prediction with write-back of both tables. The response strobes in the cycle
// after write-back, and busy is low in that same cycle, so a new branch is
// taken only after the last is written back; the chain of two dependent memory
// reads sets the spacing of branches. Only one branch is in flight, so no
// forwarding is needed. After reset a clearing pass zeroes both tables, one
// entry of each table per cycle over the larger table, with busy held high;
// config writes are taken at any time. The receiver cannot stall responses.
`timescale 1ns / 1ps

module two_level_local_branch_predictor
   import tlp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // request
   input  logic         start,
   output logic         busy,
   input  logic [63:0]  req_branch_address,
   input  logic         req_taken,
   // response
   output logic         rsp_valid,
   output logic         rsp_predicted_taken,
   output logic         rsp_correct,
   output logic         rsp_limit_hit,
   output logic [31:0]  rsp_seen_total,
   output logic [31:0]  rsp_taken_total,
   output logic [31:0]  rsp_correct_total,
   // configuration
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [31:0]  csr_branch_limit
);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_HIST  = 2'd2;
   localparam logic [1:0] S_CTR   = 2'd3;

   localparam logic [CLEAR_W-1:0] CLEAR_LAST = {CLEAR_W{1'b1}};
   localparam count_type          COUNT_MAX  = {COUNT_W{1'b1}};

   function automatic count_type sat_inc(input count_type v);
      sat_inc = (v == COUNT_MAX) ? v : v + count_type'(1);
   endfunction

   logic [1:0]         state_ff, state_in;
   logic [CLEAR_W-1:0] clr_ff, clr_in;
   hist_idx_type       hidx_ff, hidx_in;
   logic               taken_ff, taken_in;
   history_type        hist_ff, hist_in;
   count_type          seen_ff, seen_in;
   count_type          tkn_ff, tkn_in;
   count_type          corr_ff, corr_in;
   logic               limit_ff, limit_in;
   count_type          blimit_ff, blimit_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               pred_ff, pred_in;
   logic               ok_ff, ok_in;

   tbl_req_type        tbl_req;
   history_type        hist_rd_data;
   counter_type        ctr_rd_data;
   counter_type        ctr_next;
   logic               accept;

   tlp_tables u_tables (
      .clock        (clock),
      .tbl_req      (tbl_req),
      .hist_rd_data (hist_rd_data),
      .ctr_rd_data  (ctr_rd_data)
   );

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;

   // Step the counter one place toward the outcome, saturating at both ends.
   always_comb begin
      if (taken_ff) begin
         ctr_next = (ctr_rd_data == CTR_MAX) ? ctr_rd_data : ctr_rd_data + 2'd1;
      end else begin
         ctr_next = (ctr_rd_data == CTR_MIN) ? ctr_rd_data : ctr_rd_data - 2'd1;
      end
   end

   // Table ports: reads run every cycle, writes come from the clearing pass or
   // from write-back of the branch in flight (skipped once the limit froze them).
   always_comb begin
      tbl_req.hist_rd_addr = req_branch_address[HIST_IDX_W-1:0];
      tbl_req.ctr_rd_addr  = hist_rd_data;
      tbl_req.hist_we      = 1'b0;
      tbl_req.hist_wa      = hidx_ff;
      tbl_req.hist_wd      = {hist_ff[HISTORY_BITS-2:0], taken_ff};
      tbl_req.ctr_we       = 1'b0;
      tbl_req.ctr_wa       = hist_ff;
      tbl_req.ctr_wd       = ctr_next;
      if (state_ff == S_CLEAR) begin
         tbl_req.hist_we = 1'b1;
         tbl_req.hist_wa = clr_ff[HIST_IDX_W-1:0];
         tbl_req.hist_wd = '0;
         tbl_req.ctr_we  = 1'b1;
         tbl_req.ctr_wa  = clr_ff[HISTORY_BITS-1:0];
         tbl_req.ctr_wd  = CTR_MIN;
      end else if (state_ff == S_CTR && !limit_ff) begin
         tbl_req.hist_we = 1'b1;
         tbl_req.ctr_we  = 1'b1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      hidx_in      = hidx_ff;
      taken_in     = taken_ff;
      hist_in      = hist_ff;
      seen_in      = seen_ff;
      tkn_in       = tkn_ff;
      corr_in      = corr_ff;
      limit_in     = limit_ff;
      blimit_in    = (csr_valid && csr_ready) ? csr_branch_limit : blimit_ff;
      rsp_valid_in = 1'b0;
      pred_in      = pred_ff;
      ok_in        = ok_ff;

      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + CLEAR_W'(1);
            if (clr_ff == CLEAR_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               hidx_in  = req_branch_address[HIST_IDX_W-1:0];
               taken_in = req_taken;
               state_in = S_HIST;
            end
         end
         S_HIST: begin
            // hold the history; the counter read is in flight
            hist_in  = hist_rd_data;
            state_in = S_CTR;
         end
         S_CTR: begin
            pred_in      = ctr_rd_data[1];
            ok_in        = (ctr_rd_data[1] == taken_ff);
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            if (!limit_ff) begin
               seen_in = sat_inc(seen_ff);
               if (taken_ff) begin
                  tkn_in = sat_inc(tkn_ff);
               end
               if (ctr_rd_data[1] == taken_ff) begin
                  corr_in = sat_inc(corr_ff);
               end
               if (blimit_ff != '0 && sat_inc(seen_ff) == blimit_ff) begin
                  limit_in = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         seen_ff      <= '0;
         tkn_ff       <= '0;
         corr_ff      <= '0;
         limit_ff     <= 1'b0;
         blimit_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         seen_ff      <= seen_in;
         tkn_ff       <= tkn_in;
         corr_ff      <= corr_in;
         limit_ff     <= limit_in;
         blimit_ff    <= blimit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hidx_ff  <= hidx_in;
      taken_ff <= taken_in;
      hist_ff  <= hist_in;
      pred_ff  <= pred_in;
      ok_ff    <= ok_in;
   end

   // Counts change only at write-back, so they stand valid during the strobe.
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_predicted_taken = pred_ff;
   assign rsp_correct         = ok_ff;
   assign rsp_limit_hit       = limit_ff;
   assign rsp_seen_total      = seen_ff;
   assign rsp_taken_total     = tkn_ff;
   assign rsp_correct_total   = corr_ff;

   a_rsp_after_wb: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == S_CTR)
      else $error("response without write-back");

   a_clear_busy: assert property (@(posedge clock)
      state_ff == S_CLEAR |-> busy)
      else $error("not busy during clearing pass");

   a_limit_sticky: assert property (@(posedge clock) disable iff (reset)
      limit_ff |=> limit_ff)
      else $error("limit flag dropped");

   a_frozen_counts: assert property (@(posedge clock) disable iff (reset)
      (limit_ff && state_ff == S_CTR) |=> seen_ff == $past(seen_ff)
                                          && corr_ff == $past(corr_ff))
      else $error("counts moved after limit");

   a_no_wb_frozen: assert property (@(posedge clock) disable iff (reset)
      (limit_ff && state_ff != S_CLEAR) |-> !tbl_req.hist_we && !tbl_req.ctr_we)
      else $error("table write after limit");

endmodule

>>> tb/sv/two_level_local_branch_predictor_test.sv
// Self-checking testbench for the two-level local-history branch predictor.
`timescale 1ns / 1ps

module two_level_local_branch_predictor_test;
   import tlp_pkg::*;

   localparam int STALL_LIMIT = 250000;   // covers the clearing pass with margin
   localparam int LOOP_SLOTS  = 8;
   localparam int FLIP_SLOTS  = 4;

   typedef struct {
      logic        predicted_taken;
      logic        correct;
      logic        limit_hit;
      logic [31:0] seen_total;
      logic [31:0] taken_total;
      logic [31:0] correct_total;
   } branch_report_type;

   // Mirror of the predictor state plus the queue of responses still owed.
   class branch_scoreboard;
      bit [HISTORY_BITS-1:0] history_mem [HISTORY_ENTRIES];
      bit [1:0]              counter_mem [COUNTER_ENTRIES];
      bit [31:0]             seen_count;
      bit [31:0]             taken_count;
      bit [31:0]             correct_count;
      bit [31:0]             branch_limit;
      bit                    limit_hit;
      branch_report_type     awaited_reports [$];
      int                    errors;
      int                    checked;
      int                    frozen_items;

      function bit [31:0] bump(bit [31:0] v);
         return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
      endfunction

      function void note_branch(logic [63:0] addr, logic taken);
         hist_idx_type          slot;
         bit [HISTORY_BITS-1:0] hist;
         bit [1:0]              ctr;
         branch_report_type     rep;
         slot = addr[HIST_IDX_W-1:0];
         hist = history_mem[slot];
         ctr  = counter_mem[hist];
         rep.predicted_taken = ctr[1];          // upper two counter states predict taken
         rep.correct         = (ctr[1] == taken);
         if (limit_hit) begin
            frozen_items++;
         end else begin
            seen_count = bump(seen_count);
            if (taken) taken_count = bump(taken_count);
            if (rep.correct) correct_count = bump(correct_count);
            if (taken && ctr != CTR_MAX) ctr = ctr + 2'd1;
            else if (!taken && ctr != CTR_MIN) ctr = ctr - 2'd1;
            counter_mem[hist] = ctr;
            history_mem[slot] = {hist[HISTORY_BITS-2:0], taken};
            if (branch_limit != 0 && seen_count == branch_limit) limit_hit = 1'b1;
         end
         rep.limit_hit     = limit_hit;
         rep.seen_total    = seen_count;
         rep.taken_total   = taken_count;
         rep.correct_total = correct_count;
         awaited_reports.push_back(rep);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_report(branch_report_type got);
         branch_report_type want;
         if (awaited_reports.size() == 0) begin
            $error("response strobe with no branch outstanding");
            errors++;
            return;
         end
         want = awaited_reports.pop_front();
         checked++;
         compare_field("predicted_taken", 32'(want.predicted_taken), 32'(got.predicted_taken));
         compare_field("correct", 32'(want.correct), 32'(got.correct));
         compare_field("limit_hit", 32'(want.limit_hit), 32'(got.limit_hit));
         compare_field("seen_total", want.seen_total, got.seen_total);
         compare_field("taken_total", want.taken_total, got.taken_total);
         compare_field("correct_total", want.correct_total, got.correct_total);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [63:0] req_branch_address = '0;
   logic        req_taken = 1'b0;
   logic        rsp_valid;
   logic        rsp_predicted_taken;
   logic        rsp_correct;
   logic        rsp_limit_hit;
   logic [31:0] rsp_seen_total;
   logic [31:0] rsp_taken_total;
   logic [31:0] rsp_correct_total;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_branch_limit = '0;

   branch_scoreboard sb;
   bit               gaps_on = 1'b1;
   int               idle_cycles = 0;

   // Loop-shaped branches: taken for a trip count, then one not-taken exit.
   logic [63:0] loop_addr [LOOP_SLOTS];
   int          loop_trip [LOOP_SLOTS];
   int          loop_pos  [LOOP_SLOTS];
   // Branches that flip their outcome every time.
   logic [63:0] flip_addr [FLIP_SLOTS];
   logic        flip_last [FLIP_SLOTS];

   two_level_local_branch_predictor u_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_branch_address  (req_branch_address),
      .req_taken           (req_taken),
      .rsp_valid           (rsp_valid),
      .rsp_predicted_taken (rsp_predicted_taken),
      .rsp_correct         (rsp_correct),
      .rsp_limit_hit       (rsp_limit_hit),
      .rsp_seen_total      (rsp_seen_total),
      .rsp_taken_total     (rsp_taken_total),
      .rsp_correct_total   (rsp_correct_total),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_branch_limit    (csr_branch_limit)
   );

   always #10 clock = ~clock;

   // Sample the response strobe at the edge that ends its cycle; an X strobe
   // counts as a response so that it cannot slip by unchecked.
   always @(posedge clock) begin
      branch_report_type got;
      got.predicted_taken = rsp_predicted_taken;
      got.correct         = rsp_correct;
      got.limit_hit       = rsp_limit_hit;
      got.seen_total      = rsp_seen_total;
      got.taken_total     = rsp_taken_total;
      got.correct_total   = rsp_correct_total;
      if (!reset && rsp_valid !== 1'b0) sb.check_report(got);
   end

   // Watchdog: restart on any transfer, give up after a long silent stretch.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Present one branch, hold it until the transfer, then note it and maybe idle.
   task automatic send_branch(input logic [63:0] addr, input logic taken);
      start              <= 1'b1;
      req_branch_address <= addr;
      req_taken          <= taken;
      @(posedge clock);
      while (busy) @(posedge clock);
      sb.note_branch(addr, taken);
      if (gaps_on && $urandom_range(99) < 7) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // Drop start and hold until every owed response has come back.
   task automatic drain;
      start <= 1'b0;
      while (sb.awaited_reports.size() != 0) @(posedge clock);
   endtask

   // Write the branch limit; only called with nothing in flight.
   task automatic write_limit(input logic [31:0] value);
      csr_valid        <= 1'b1;
      csr_branch_limit <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.branch_limit = value;
      csr_valid <= 1'b0;
   endtask

   // Mostly well-formed branch streams that train the counters; the rest is
   // aliasing addresses and pure noise.
   task automatic random_burst(input int count);
      int          pick;
      int          h;
      logic [63:0] addr;
      logic        taken;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            h     = $urandom_range(LOOP_SLOTS - 1);
            addr  = loop_addr[h];
            taken = (loop_pos[h] != loop_trip[h]);
            loop_pos[h] = taken ? loop_pos[h] + 1 : 0;
         end else if (pick < 75) begin
            h     = $urandom_range(FLIP_SLOTS - 1);
            addr  = flip_addr[h];
            taken = ~flip_last[h];
            flip_last[h] = taken;
         end else if (pick < 85) begin
            // Same history slot as a loop branch, different upper bits.
            h     = $urandom_range(LOOP_SLOTS - 1);
            addr  = {$urandom, $urandom};
            addr[HIST_IDX_W-1:0] = loop_addr[h][HIST_IDX_W-1:0];
            taken = 1'($urandom_range(1));
         end else begin
            addr  = {$urandom, $urandom};
            taken = 1'($urandom_range(1));
         end
         send_branch(addr, taken);
      end
   endtask

   initial begin
      sb = new();
      for (int i = 0; i < LOOP_SLOTS; i++) begin
         loop_addr[i] = {$urandom, $urandom};
         loop_trip[i] = $urandom_range(2, 7);
         loop_pos[i]  = 0;
      end
      for (int i = 0; i < FLIP_SLOTS; i++) begin
         flip_addr[i] = {$urandom, $urandom};
         flip_last[i] = 1'b0;
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      write_limit(32'd0);

      // Directed: all histories start at zero, so these share counter zero.
      // Hold it at its floor, walk it up past its ceiling, then mispredict.
      send_branch(64'd0, 1'b0);
      for (int a = 1; a <= 4; a++) send_branch(64'(a), 1'b1);
      send_branch(64'd5, 1'b0);
      send_branch(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      send_branch(64'hFFFF_FFFF_FFFF_F001, 1'b0);   // aliases slot 1
      // Fill one history with ones, then shift one more out the top.
      for (int k = 0; k < 17; k++) send_branch(64'd7, 1'b1);

      // Highest limit: never reached in this run.
      drain;
      write_limit(32'hFFFF_FFFF);
      gaps_on = 1'b0;
      random_burst(200);
      gaps_on = 1'b1;
      random_burst(200);

      // Limit equal to the count already passed: must not raise the flag.
      drain;
      write_limit(sb.seen_count);
      random_burst(200);

      // Limit far below the count.
      drain;
      write_limit(32'd1);
      random_burst(200);

      // Reachable limit: the flag rises mid-burst and the tables freeze after.
      drain;
      write_limit(sb.seen_count + 32'd300);
      random_burst(420);

      drain;
      repeat (8) @(posedge clock);

      if (sb.awaited_reports.size() != 0)
         $error("%0d responses never arrived", sb.awaited_reports.size());
      $display("Checked %0d responses; model counts seen %0d, taken %0d, correct %0d.",
               sb.checked, sb.seen_count, sb.taken_count, sb.correct_count);
      $display("Limits 0, max, passed and reached; flag %0d, %0d branches after freeze.",
               sb.limit_hit, sb.frozen_items);
      if (sb.errors == 0 && sb.awaited_reports.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
